// ===== src/triangle_depth_rasterizer_unit_assert.svh =====
// Assertion macros for the triangle depth rasterizer.
`ifndef TRIANGLE_DEPTH_RASTERIZER_UNIT_ASSERT_SVH
`define TRIANGLE_DEPTH_RASTERIZER_UNIT_ASSERT_SVH
// Checks that a condition implies another on the same edge.
`define TDR_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Checks that a condition implies another on the next edge.
`define TDR_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// ===== src/tdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared types and constants of the triangle depth rasterizer.
// ----------------------------------------------------------------------------
package tdr_pkg;
    localparam logic ACT_DRAW = 1'b0;
    localparam logic ACT_READ = 1'b1;
    localparam logic REG_WIDTH = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam logic [31:0] DEPTH_FLOOR = 32'h8000_0000;
    localparam int LANES = 3;

    typedef struct packed {
        logic        action;
        logic [31:0] v0_xy;
        logic signed [31:0] v0_depth;
        logic [23:0] v0_inv_w;
        logic [31:0] v1_xy;
        logic signed [31:0] v1_depth;
        logic [23:0] v1_inv_w;
        logic [31:0] v2_xy;
        logic signed [31:0] v2_depth;
        logic [23:0] v2_inv_w;
        logic [15:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_depth;
        logic        drawn;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_AREA, ST_SETUP, ST_PIX, ST_EDGE, ST_WEIGHT,
        ST_NORM, ST_DIV, ST_RDWAIT, ST_CMP, ST_READ, ST_OUT
    } state_t;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;
endpackage

// ===== src/tdr_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_lane
// One edge lane: edge function, weight product and weighted depth.
// ----------------------------------------------------------------------------
module tdr_lane (
    input  logic               clk,
    input  logic               en_e,
    input  logic               en_p,
    input  logic               en_q,
    input  logic signed [16:0] dx,
    input  logic signed [16:0] dy,
    input  logic signed [16:0] ax,
    input  logic signed [16:0] ay,
    input  logic signed [17:0] px,
    input  logic signed [17:0] py,
    input  logic [23:0]        inv_w,
    input  logic signed [31:0] depth,
    input  logic [5:0]         shift,
    output logic signed [36:0] edge_val,
    output logic [61:0]        weight,
    output logic [29:0]        q,
    output logic signed [62:0] qz
);
    logic signed [36:0] e_reg;
    logic [61:0]        p_reg;
    logic [29:0]        q_reg;
    logic signed [62:0] qz_reg;
    logic signed [18:0] rx;
    logic signed [18:0] ry;
    logic [29:0]        q_next;

    assign rx = 19'(px) - 19'(ax);
    assign ry = 19'(py) - 19'(ay);
    assign q_next = 30'(p_reg >> shift);

    // Edge value, its weight, then the normalized weight times depth.
    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            e_reg <= 37'(dx * ry) - 37'(dy * rx);
        end
        if (en_p)
        begin
            p_reg <= 62'($unsigned(e_reg[36:0])) * 62'(inv_w);
        end
        if (en_q)
        begin
            q_reg <= q_next;
            qz_reg <= $signed({1'b0, q_next}) * 63'(depth);
        end
    end

    assign edge_val = e_reg;
    assign weight = p_reg;
    assign q = q_reg;
    assign qz = qz_reg;
endmodule

// ===== src/tdr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_div
// Radix-2 floor divider of a signed numerator by a positive divisor.
// ----------------------------------------------------------------------------
module tdr_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [64:0] num,
    input  logic [31:0]        den,
    output tdr_pkg::div_stat_t stat,
    output logic signed [63:0] quot
);
    import tdr_pkg::*;
    logic [64:0] rem_reg, rem_next;
    logic [64:0] q_reg, q_next;
    logic [31:0] d_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] mag;
    logic [64:0] qa;

    assign mag = num[64] ? 65'(-num) : 65'(num);
    assign trial = {rem_reg[63:0], q_reg[64]};

    // One quotient bit per cycle.
    always_comb
    begin
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            q_next = mag;
            cnt_next = 7'd65;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= 65'(d_reg))
            begin
                rem_next = trial - 65'(d_reg);
                q_next = {q_reg[63:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[63:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        if (start)
        begin
            d_reg <= den;
            neg_reg <= num[64];
        end
    end

    // Floor for negative numerators: negate and step down on a remainder.
    assign qa = q_reg + ((rem_reg != '0) ? 65'd1 : 65'd0);
    assign quot = neg_reg ? 64'(-qa) : 64'(q_reg);
    assign stat = '{busy: busy_reg, done: done_reg};
endmodule

// ===== src/triangle_depth_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// A read or a culled draw goes straight to the result. A drawn triangle walks its bounding box
// pixel by pixel; an uncovered pixel skips weights and division, one whose weights sum
// to zero skips the division, and a covered one waits on the one-bit-per-cycle depth
// divider shared by all pixels. One item is in flight at a time; the result register
// frees the input while a beat waits. Reset: a clearing pass fills the store.
// ----------------------------------------------------------------------------
// triangle_depth_rasterizer_unit
// Edge-function triangle rasterizer with an on-chip depth store.
// ----------------------------------------------------------------------------
module triangle_depth_rasterizer_unit #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tdr_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tdr_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [8:0]          cfg_data
);
    import tdr_pkg::*;
    localparam int SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = $clog2(SIZE);
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 1);

    logic [31:0] mem [SIZE];
    logic [31:0] rd_reg;

    state_t state_reg, state_next;
    in_item_t item_reg;
    out_item_t out_reg, out_next;
    out_item_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;
    logic [8:0] w_cfg_reg, h_cfg_reg;
    logic [AW-1:0] clr_reg, clr_next;
    logic signed [17:0] x_reg, x_next, y_reg, y_next;
    logic signed [17:0] xlo_reg, xlo_next, xhi_reg, xhi_next, yhi_reg, yhi_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic signed [31:0] z_reg;
    logic [5:0] shift_reg, shift_next;
    // Depth of the pixel under test is valid only after a division.
    logic z_valid_reg;

    // Vertex fields.
    logic signed [15:0] vx0, vy0, vx1, vy1, vx2, vy2;
    assign vx0 = item_reg.v0_xy[31:16];
    assign vy0 = item_reg.v0_xy[15:0];
    assign vx1 = item_reg.v1_xy[31:16];
    assign vy1 = item_reg.v1_xy[15:0];
    assign vx2 = item_reg.v2_xy[31:16];
    assign vy2 = item_reg.v2_xy[15:0];

    // Effective screen size.
    logic [XW-1:0] w_eff;
    logic [YW-1:0] h_eff;
    always_comb
    begin
        if (w_cfg_reg == 9'd0) w_eff = XW'(1);
        else if (32'(w_cfg_reg) > 32'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
        else w_eff = XW'(w_cfg_reg);
        if (h_cfg_reg == 9'd0) h_eff = YW'(1);
        else if (32'(h_cfg_reg) > 32'(MAX_HEIGHT)) h_eff = YW'(MAX_HEIGHT);
        else h_eff = YW'(h_cfg_reg);
    end

    // Signed area, computed in two halves on registered products.
    logic signed [33:0] area_a_reg, area_b_reg;
    logic signed [34:0] area;
    assign area = 35'(area_a_reg) - 35'(area_b_reg);

    // Bounding box from truncated vertex extremes.
    logic signed [15:0] mnx, mny, mxx, mxy;
    always_comb
    begin
        mnx = (vx0 < vx1) ? vx0 : vx1; if (vx2 < mnx) mnx = vx2;
        mny = (vy0 < vy1) ? vy0 : vy1; if (vy2 < mny) mny = vy2;
        mxx = (vx0 > vx1) ? vx0 : vx1; if (vx2 > mxx) mxx = vx2;
        mxy = (vy0 > vy1) ? vy0 : vy1; if (vy2 > mxy) mxy = vy2;
    end
    // Truncation toward zero; the magnitude is taken at 18 bits so the most
    // negative coordinate keeps its sign.
    function automatic logic signed [17:0] tpix(input logic signed [15:0] v);
        logic signed [17:0] a;
        a = v[15] ? -18'(v) : 18'(v);
        a = a >>> 4;
        return v[15] ? -a : a;
    endfunction

    // Lanes: edge 12, edge 20, edge 01.
    logic en_e, en_p, en_q;
    logic signed [36:0] e [LANES];
    logic [61:0] p [LANES];
    logic [29:0] q [LANES];
    logic signed [62:0] qz [LANES];
    logic signed [17:0] px, py;
    assign px = x_reg <<< 4;
    assign py = y_reg <<< 4;

    tdr_lane u_lane0 (.clk, .en_e, .en_p, .en_q,
        .dx(17'(vx2) - 17'(vx1)), .dy(17'(vy2) - 17'(vy1)), .ax(17'(vx1)), .ay(17'(vy1)),
        .px, .py, .inv_w(item_reg.v0_inv_w), .depth(item_reg.v0_depth),
        .shift(shift_reg), .edge_val(e[0]), .weight(p[0]), .q(q[0]), .qz(qz[0]));
    tdr_lane u_lane1 (.clk, .en_e, .en_p, .en_q,
        .dx(17'(vx0) - 17'(vx2)), .dy(17'(vy0) - 17'(vy2)), .ax(17'(vx2)), .ay(17'(vy2)),
        .px, .py, .inv_w(item_reg.v1_inv_w), .depth(item_reg.v1_depth),
        .shift(shift_reg), .edge_val(e[1]), .weight(p[1]), .q(q[1]), .qz(qz[1]));
    tdr_lane u_lane2 (.clk, .en_e, .en_p, .en_q,
        .dx(17'(vx1) - 17'(vx0)), .dy(17'(vy1) - 17'(vy0)), .ax(17'(vx0)), .ay(17'(vy0)),
        .px, .py, .inv_w(item_reg.v2_inv_w), .depth(item_reg.v2_depth),
        .shift(shift_reg), .edge_val(e[2]), .weight(p[2]), .q(q[2]), .qz(qz[2]));

    // Merge: coverage, weight sum and normalizing shift.
    logic covered;
    logic [63:0] s_sum;
    logic [5:0] s_calc;
    assign covered = !e[0][36] && !e[1][36] && !e[2][36];
    assign s_sum = 64'(p[0]) + 64'(p[1]) + 64'(p[2]);
    always_comb
    begin
        s_calc = '0;
        for (int k = 63; k >= 30; k--)
        begin
            if (s_sum[k] && s_calc == '0) s_calc = 6'(k - 29);
        end
    end
    logic [31:0] den;
    logic signed [64:0] num;
    assign den = 32'(q[0]) + 32'(q[1]) + 32'(q[2]);
    assign num = 65'(qz[0]) + 65'(qz[1]) + 65'(qz[2]);

    div_stat_t dstat;
    logic div_start;
    logic signed [63:0] quot;
    tdr_div u_div (.clk, .rst_n, .start(div_start), .num, .den, .stat(dstat), .quot);

    logic [AW-1:0] pix_idx;
    assign pix_idx = AW'(x_reg) + AW'(y_reg) * AW'(w_eff);

    // Control sequencer.
    logic mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0] mem_wd;
    always_comb
    begin
        state_next = state_reg;
        out_next = out_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg;
        clr_next = clr_reg;
        x_next = x_reg; y_next = y_reg;
        xlo_next = xlo_reg; xhi_next = xhi_reg; yhi_next = yhi_reg;
        idx_next = idx_reg;
        shift_next = shift_reg;
        en_e = 1'b0; en_p = 1'b0; en_q = 1'b0;
        div_start = 1'b0;
        mem_we = 1'b0; mem_wa = idx_reg; mem_wd = z_reg;
        in_ready = 1'b0;
        if (out_valid_reg && out_ready) out_valid_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1; mem_wa = clr_reg; mem_wd = DEPTH_FLOOR;
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == SIZE - 1) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_ready)
                begin
                    state_next = (in_data.action == ACT_READ) ? ST_READ : ST_AREA;
                end
            end
            ST_READ: state_next = ST_RDWAIT;
            ST_RDWAIT:
            begin
                res_next.read_depth = (32'(item_reg.read_index) < SIZE) ? rd_reg : 32'd0;
                res_next.drawn = 1'b0;
                state_next = ST_OUT;
            end
            ST_AREA: state_next = ST_SETUP;
            ST_SETUP:
            begin
                if (area <= 0)
                begin
                    res_next = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    xlo_next = (tpix(mnx) < 0) ? 18'sd0 : tpix(mnx);
                    x_next = xlo_next;
                    y_next = (tpix(mny) < 0) ? 18'sd0 : tpix(mny);
                    xhi_next = (tpix(mxx) > $signed(18'(w_eff) - 18'sd1))
                        ? $signed(18'(w_eff) - 18'sd1) : tpix(mxx);
                    yhi_next = (tpix(mxy) > $signed(18'(h_eff) - 18'sd1))
                        ? $signed(18'(h_eff) - 18'sd1) : tpix(mxy);
                    state_next = ST_PIX;
                end
            end
            ST_PIX:
            begin
                if (y_reg > yhi_reg || xlo_reg > xhi_reg)
                begin
                    res_next.read_depth = '0;
                    res_next.drawn = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    en_e = 1'b1;
                    idx_next = pix_idx;
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                if (covered)
                begin
                    en_p = 1'b1;
                    state_next = ST_WEIGHT;
                end
                else state_next = ST_CMP;
            end
            ST_WEIGHT:
            begin
                shift_next = s_calc;
                state_next = (s_sum == 64'd0) ? ST_CMP : ST_NORM;
            end
            ST_NORM:
            begin
                en_q = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!dstat.busy && !dstat.done) div_start = 1'b1;
                if (dstat.done) state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (z_valid_reg && $signed(z_reg) > $signed(rd_reg))
                begin
                    mem_we = 1'b1;
                end
                if (x_reg >= xhi_reg)
                begin
                    x_next = xlo_reg;
                    y_next = y_reg + 18'sd1;
                end
                else x_next = x_reg + 18'sd1;
                state_next = ST_PIX;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers and screen configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            clr_reg <= '0;
            w_cfg_reg <= 9'd256;
            h_cfg_reg <= 9'd256;
            z_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            clr_reg <= clr_next;
            if (dstat.done) z_valid_reg <= 1'b1;
            else if (state_reg == ST_CMP) z_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WIDTH: w_cfg_reg <= cfg_data;
                    REG_HEIGHT: h_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        res_reg <= res_next;
        x_reg <= x_next; y_reg <= y_next;
        xlo_reg <= xlo_next; xhi_reg <= xhi_next; yhi_reg <= yhi_next;
        idx_reg <= idx_next;
        shift_reg <= shift_next;
        if (in_valid && in_ready) item_reg <= in_data;
        if (state_reg == ST_AREA)
        begin
            area_a_reg <= 34'(17'(vx1) - 17'(vx0)) * 34'(17'(vy2) - 17'(vy0));
            area_b_reg <= 34'(17'(vy1) - 17'(vy0)) * 34'(17'(vx2) - 17'(vx0));
        end
        if (dstat.done) z_reg <= quot[31:0];
    end

    // Depth store: one write port, one registered read port.
    logic [AW-1:0] rd_addr;
    assign rd_addr = (state_reg == ST_READ) ? AW'(item_reg.read_index) : idx_reg;
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        rd_reg <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    `include "triangle_depth_rasterizer_unit_assert.svh"
    `TDR_ASSERT_IMP(a_no_accept_busy, state_reg != ST_IDLE, !in_ready)
    `TDR_ASSERT_NEXT(a_out_after_out_state, state_reg == ST_OUT && state_next == ST_IDLE,
        out_valid)
    `TDR_ASSERT_IMP(a_no_write_in_idle, state_reg == ST_IDLE, !mem_we)
    `TDR_ASSERT_IMP(a_div_idle_outside, dstat.busy, state_reg == ST_DIV)
endmodule

// ===== sim/tdr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_checker
// Watches the draw/read and result channels of the rasterizer, keeps its own
// depth store and screen size, predicts every result and compares each
// result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tdr_checker
    import tdr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_item_t   in_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_item_t  out_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data,
    output int         errors,
    output int         pending
);
    logic [31:0] depth_mem [65536];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    out_item_t   expected_q [$];

    // Register values outside the legal range act as the nearest legal one.
    function automatic longint eff_dim(logic [8:0] r);
        if (r == 0)
            return 1;
        if (r > 256)
            return 256;
        return r;
    endfunction

    // Walks the clamped bounding box and keeps the larger depth per pixel.
    function automatic logic rasterize(in_item_t it);
        longint vx [3];
        longint vy [3];
        longint vz [3];
        longint unsigned vw [3];
        longint e [3];
        longint unsigned p [3];
        longint unsigned wsum;
        longint area, wd, ht, bx0, by0, bx1, by1, px, py, num, den, q, z;
        int sh;
        logic [31:0] xy [3];
        xy[0] = it.v0_xy;
        xy[1] = it.v1_xy;
        xy[2] = it.v2_xy;
        vz[0] = longint'(it.v0_depth);
        vz[1] = longint'(it.v1_depth);
        vz[2] = longint'(it.v2_depth);
        vw[0] = it.v0_inv_w;
        vw[1] = it.v1_inv_w;
        vw[2] = it.v2_inv_w;
        for (int i = 0; i < 3; i++)
        begin
            vx[i] = longint'($signed(xy[i][31:16]));
            vy[i] = longint'($signed(xy[i][15:0]));
        end
        area = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vy[1] - vy[0]) * (vx[2] - vx[0]);
        if (area <= 0)
            return 1'b0;
        wd = eff_dim(width_reg);
        ht = eff_dim(height_reg);
        bx0 = vx[0];
        bx1 = vx[0];
        by0 = vy[0];
        by1 = vy[0];
        for (int i = 1; i < 3; i++)
        begin
            if (vx[i] < bx0) bx0 = vx[i];
            if (vx[i] > bx1) bx1 = vx[i];
            if (vy[i] < by0) by0 = vy[i];
            if (vy[i] > by1) by1 = vy[i];
        end
        // Division by 16 truncates toward zero, as the box rule wants.
        bx0 = bx0 / 16;
        bx1 = bx1 / 16;
        by0 = by0 / 16;
        by1 = by1 / 16;
        if (bx0 < 0) bx0 = 0;
        if (by0 < 0) by0 = 0;
        if (bx1 > wd - 1) bx1 = wd - 1;
        if (by1 > ht - 1) by1 = ht - 1;
        for (longint y = by0; y <= by1; y++)
        begin
            for (longint x = bx0; x <= bx1; x++)
            begin
                px = x * 16;
                py = y * 16;
                e[0] = (vx[2] - vx[1]) * (py - vy[1]) - (vy[2] - vy[1]) * (px - vx[1]);
                e[1] = (vx[0] - vx[2]) * (py - vy[2]) - (vy[0] - vy[2]) * (px - vx[2]);
                e[2] = (vx[1] - vx[0]) * (py - vy[0]) - (vy[1] - vy[0]) * (px - vx[0]);
                if (e[0] < 0 || e[1] < 0 || e[2] < 0)
                    continue;
                wsum = 0;
                for (int i = 0; i < 3; i++)
                begin
                    p[i] = longint'(unsigned'(e[i])) * vw[i];
                    wsum += p[i];
                end
                // A zero weight sum leaves the depth undefined; skip the pixel.
                if (wsum == 0)
                    continue;
                sh = 0;
                while ((wsum >> sh) >= (64'd1 << 30))
                    sh++;
                num = 0;
                den = 0;
                for (int i = 0; i < 3; i++)
                begin
                    q = longint'(p[i] >> sh);
                    den += q;
                    num += q * vz[i];
                end
                if (den <= 0)
                    continue;
                // Floor division of a possibly negative numerator.
                z = num / den;
                if (num % den != 0 && num < 0)
                    z--;
                if (z > longint'($signed(depth_mem[x + y * wd])))
                    depth_mem[x + y * wd] = z[31:0];
            end
        end
        return 1'b1;
    endfunction

    // Tracks the configuration, predicts on input beats, checks output beats.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_item;
        out_item_t pred;
        if (!rst_n)
        begin
            foreach (depth_mem[i])
                depth_mem[i] = DEPTH_FLOOR;
            width_reg  = 9'd256;
            height_reg = 9'd256;
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                pred = '0;
                if (in_data.action == ACT_READ)
                    pred.read_depth = depth_mem[in_data.read_index];
                else
                    pred.drawn = rasterize(in_data);
                expected_q.push_back(pred);
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none actual %h", $time,
                             out_data);
                end
                else
                begin
                    exp_item = expected_q.pop_front();
                    if (exp_item.read_depth !== out_data.read_depth)
                    begin
                        errors++;
                        $display("%0t: read_depth expected %h actual %h", $time,
                                 exp_item.read_depth, out_data.read_depth);
                    end
                    if (exp_item.drawn !== out_data.drawn)
                    begin
                        errors++;
                        $display("%0t: drawn expected %b actual %b", $time,
                                 exp_item.drawn, out_data.drawn);
                    end
                end
            end
        end
        pending = expected_q.size();
    end
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives draw and read beats into the rasterizer across several screen
// sizes, with random idle bursts on both channels; the checker predicts and
// compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import tdr_pkg::*;

    localparam int STALL_LIMIT = 400000;
    localparam int PHASES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_we = 1'b0;
    logic       cfg_index = REG_WIDTH;
    logic [8:0] cfg_data = '0;
    int         errors;
    int         pending;
    logic       quiet = 1'b0;
    int         ready_run = 0;
    int         stall_cycles = 0;
    int         cur_w = 256;
    int         cur_h = 256;

    triangle_depth_rasterizer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tdr_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure in random bursts; always ready when quiet.
    always @(posedge clk)
    begin
        if (quiet)
            out_ready <= 1'b1;
        else if (ready_run == 0)
        begin
            out_ready <= ($urandom_range(0, 2) != 0);
            ready_run <= $urandom_range(1, 9);
        end
        else
            ready_run <= ready_run - 1;
    end

    // Ends the run when no beat moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("triangle_depth_rasterizer_unit: mismatch");
            $finish;
        end
    end

    // Presents one beat and holds it until accepted, then maybe idles.
    task automatic send_beat(in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Writes both screen registers once the block has drained.
    task automatic set_screen(int w, int h);
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= w[8:0];
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= h[8:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = (w == 0) ? 1 : (w > 256 ? 256 : w);
        cur_h = (h == 0) ? 1 : (h > 256 ? 256 : h);
    endtask

    function automatic in_item_t make_draw(int ax, int ay, int bx, int by, int cx, int cy,
                                           logic [31:0] za, logic [31:0] zb,
                                           logic [31:0] zc, logic [23:0] wa,
                                           logic [23:0] wb, logic [23:0] wc);
        in_item_t it;
        it = '0;
        it.action   = ACT_DRAW;
        it.v0_xy    = {ax[15:0], ay[15:0]};
        it.v1_xy    = {bx[15:0], by[15:0]};
        it.v2_xy    = {cx[15:0], cy[15:0]};
        it.v0_depth = za;
        it.v1_depth = zb;
        it.v2_depth = zc;
        it.v0_inv_w = wa;
        it.v1_inv_w = wb;
        it.v2_inv_w = wc;
        it.read_index = 16'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_read(int idx);
        in_item_t it;
        it = '0;
        it.action = ACT_READ;
        it.read_index = idx[15:0];
        return it;
    endfunction

    // A small triangle near the screen with random winding and content.
    function automatic in_item_t small_triangle();
        int span, mx, my;
        int c [6];
        span = ($urandom_range(0, 7) == 0) ? 256 : 96;
        mx = $urandom_range(0, cur_w * 16 + 64) - 32;
        my = $urandom_range(0, cur_h * 16 + 64) - 32;
        for (int i = 0; i < 3; i++)
        begin
            c[2 * i]     = mx + $urandom_range(0, 2 * span) - span;
            c[2 * i + 1] = my + $urandom_range(0, 2 * span) - span;
        end
        return make_draw(c[0], c[1], c[2], c[3], c[4], c[5], $urandom, $urandom, $urandom,
                         24'($urandom), 24'($urandom), 24'($urandom));
    endfunction

    // Every field random; only used on small screens so the box stays small.
    function automatic in_item_t noise_item();
        in_item_t it;
        it.action     = 1'($urandom);
        it.v0_xy      = $urandom;
        it.v0_depth   = $urandom;
        it.v0_inv_w   = 24'($urandom);
        it.v1_xy      = $urandom;
        it.v1_depth   = $urandom;
        it.v1_inv_w   = 24'($urandom);
        it.v2_xy      = $urandom;
        it.v2_depth   = $urandom;
        it.v2_inv_w   = 24'($urandom);
        it.read_index = 16'($urandom);
        return it;
    endfunction

    initial
    begin
        int pw [PHASES];
        int ph [PHASES];
        int pick;
        pw = '{0, 511, 1, 40, 256, 511, 17, 256};
        ph = '{0, 1, 511, 30, 256, 511, 9, 256};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on an 8 by 8 screen.
        set_screen(8, 8);
        send_beat(make_read(0));
        send_beat(make_read(65535));
        send_beat(make_draw(0, 0, 112, 0, 0, 112, 32'h0100_0000, 32'h0100_0000,
                            32'h0100_0000, 24'h10_0000, 24'h10_0000, 24'h10_0000));
        send_beat(make_read(0));
        send_beat(make_read(9));
        // Clockwise winding is culled.
        send_beat(make_draw(0, 0, 0, 112, 112, 0, 32'h7F00_0000, 32'h7F00_0000,
                            32'h7F00_0000, 24'h10_0000, 24'h10_0000, 24'h10_0000));
        // Zero area: a single point, then three points on one line.
        send_beat(make_draw(40, 40, 40, 40, 40, 40, 32'h7F00_0000, 0, 0, 1, 1, 1));
        send_beat(make_draw(0, 0, 32, 32, 64, 64, 32'h7F00_0000, 0, 0, 1, 1, 1));
        // All reciprocal w zero: walked but nothing written.
        send_beat(make_draw(0, 0, 112, 0, 0, 112, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 0, 0, 0));
        send_beat(make_read(0));
        // Extreme depths and weights, vertices on pixel centers.
        send_beat(make_draw(16, 16, 96, 16, 16, 96, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h0000_0000, 24'hFF_FFFF, 24'h00_0000, 24'h00_0001));
        send_beat(make_read(9));
        send_beat(make_read(10));
        // Extreme coordinates: the box spans the whole clamped screen, the triangle misses it.
        send_beat(make_draw(-32768, -32768, 32767, -32768, -32768, 32767, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0001, 24'hFF_FFFF, 24'hFF_FFFF,
                            24'hFF_FFFF));
        // Entirely left of the screen: empty box.
        send_beat(make_draw(-200, 0, -100, 0, -200, 100, 32'h7F00_0000, 32'h7F00_0000,
                            32'h7F00_0000, 24'h10_0000, 24'h10_0000, 24'h10_0000));
        // Lower depth than stored must not overwrite.
        send_beat(make_draw(0, 0, 112, 0, 0, 112, 32'h0000_0001, 32'h0000_0001,
                            32'h0000_0001, 24'h10_0000, 24'h10_0000, 24'h10_0000));
        send_beat(make_read(0));
        send_beat(make_read(63));
        send_beat(make_read(27));

        // Random phases over several screen sizes; the last one runs without idling.
        for (int p = 0; p < PHASES; p++)
        begin
            set_screen(pw[p], ph[p]);
            if (p == PHASES - 1)
                quiet = 1'b1;
            for (int n = 0; n < 50; n++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 4 && cur_w * cur_h <= 1200)
                    send_beat(noise_item());
                else if (pick < 9)
                    send_beat(make_read($urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                        : $urandom_range(0, cur_w * cur_h - 1)));
                else
                    send_beat(small_triangle());
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("triangle_depth_rasterizer_unit: match");
        else
            $display("triangle_depth_rasterizer_unit: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/tdr_pkg.sv
src/tdr_lane.sv
src/tdr_div.sv
src/triangle_depth_rasterizer_unit.sv
sim/tdr_checker.sv
sim/tb_top.sv
